/* hw/rtl/cfsp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cfsp_pkg
// Types and constants shared by the current fuse and sample packer.
// ----------------------------------------------------------------------------
package cfsp_pkg;

   // Width of one converter code and of one packed byte.
   localparam int unsigned CODE_W = 10;
   localparam int unsigned BYTE_W = 8;

   // Full-scale converter code; the inverted code of a raw zero.
   localparam logic [CODE_W-1:0] CODE_FULL_SCALE = 10'd1023;

   // Peak values below this threshold are flagged on every result.
   localparam logic [CODE_W-1:0] PEAK_LOW_LIMIT = 10'd102;

   // Division by ten of a 10-bit code: multiply by 205 and drop 11 bits.
   // The result is exact for every value up to 1028.
   localparam int unsigned      DIV10_PROD_W = 18;
   localparam int unsigned      DIV10_SHIFT  = 11;
   localparam logic [DIV10_PROD_W-1:0] DIV10_MUL = 18'd205;

   // Register reset values.
   localparam logic [CODE_W-1:0] TRIP_LIMIT_RESET    = 10'd1023;
   localparam logic [CODE_W-1:0] ZERO_CURRENT_RESET  = 10'd0;
   localparam logic [7:0]        DECIMATION_RESET    = 8'd1;
   localparam logic [CODE_W-1:0] CAPTURE_BYTES_RESET = 10'd800;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_TRIP_LIMIT    = 2'd0,
      CSR_ZERO_CURRENT  = 2'd1,
      CSR_DECIMATION    = 2'd2,
      CSR_CAPTURE_BYTES = 2'd3
   } csr_index_type;

   // Kind of an input item.
   typedef enum logic [1:0] {
      KIND_SAMPLE    = 2'd0,
      KIND_POWER_ON  = 2'd1,
      KIND_START     = 2'd2,
      KIND_POWER_OFF = 2'd3
   } kind_type;

   // Supply mode.
   typedef enum logic [1:0] {
      MODE_OFF     = 2'd0,
      MODE_ON      = 2'd1,
      MODE_TRIPPED = 2'd2,
      MODE_CAPTURE = 2'd3
   } mode_type;

   // Pack position within a group of four samples.
   typedef enum logic [1:0] {
      PHASE_0 = 2'd0,
      PHASE_1 = 2'd1,
      PHASE_2 = 2'd2,
      PHASE_3 = 2'd3
   } phase_type;

   // Outcome of packing one kept sample.
   typedef struct packed {
      logic [BYTE_W-1:0] byte_first;
      logic [BYTE_W-1:0] byte_second;
      logic [1:0]        bytes_out;
      phase_type         phase_next;
      logic [BYTE_W-1:0] partial_next;
      logic [CODE_W-1:0] emitted_next;
      logic              done;
   } pack_result_type;

endpackage
`default_nettype wire

/* hw/rtl/cfsp_pack.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cfsp_pack
// Packs one corrected 10-bit sample into the byte stream, MSB first, four
// samples to five bytes, and counts emitted bytes against the limit.
// ----------------------------------------------------------------------------
module cfsp_pack
   import cfsp_pkg::*;
(
   input  wire logic [CODE_W-1:0] value,
   input  wire phase_type         phase,
   input  wire logic [BYTE_W-1:0] partial,
   input  wire logic [CODE_W-1:0] emitted,
   input  wire logic [CODE_W-1:0] limit,
   output pack_result_type        result
);

   logic [BYTE_W-1:0] merged;
   logic [BYTE_W-1:0] leftover;
   logic              emit_first;
   logic              emit_second;
   logic [CODE_W-1:0] emitted_one;
   logic [CODE_W-1:0] emitted_two;

   // Merge the top bits of the sample into the open byte and keep the rest.
   always_comb begin
      case (phase)
         PHASE_0: begin
            merged   = partial | value[9:2];
            leftover = {value[1:0], 6'd0};
         end
         PHASE_1: begin
            merged   = partial | {2'd0, value[9:4]};
            leftover = {value[3:0], 4'd0};
         end
         PHASE_2: begin
            merged   = partial | {4'd0, value[9:6]};
            leftover = {value[5:0], 2'd0};
         end
         default: begin
            merged   = partial | {6'd0, value[9:8]};
            leftover = value[7:0];
         end
      endcase
   end

   // Byte emission against the limit; the last phase closes a second byte.
   always_comb begin
      emit_first  = emitted < limit;
      emitted_one = emit_first ? emitted + 10'd1 : emitted;
      emit_second = (phase == PHASE_3) && (emitted_one < limit);
      emitted_two = emit_second ? emitted_one + 10'd1 : emitted_one;
   end

   // Assemble the outcome, ending the capture once the limit is reached.
   always_comb begin
      result.byte_first  = emit_first  ? merged   : '0;
      result.byte_second = emit_second ? leftover : '0;
      result.bytes_out   = {1'b0, emit_first} + {1'b0, emit_second};
      result.done        = emitted_two >= limit;
      if (result.done) begin
         result.phase_next   = PHASE_0;
         result.partial_next = '0;
         result.emitted_next = '0;
      end else if (phase == PHASE_3) begin
         result.phase_next   = PHASE_0;
         result.partial_next = '0;
         result.emitted_next = emitted_two;
      end else begin
         result.phase_next   = phase_type'(phase + 2'd1);
         result.partial_next = leftover;
         result.emitted_next = emitted_two;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/current_fuse_and_sample_packer_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// current_fuse_and_sample_packer_unit
// Electronic fuse on 10-bit current samples with capture and byte packing.
// ----------------------------------------------------------------------------
// Every input item (a sample or a power event) gives exactly one result item
// in the cycle after it is accepted. The block takes one item per clock: the
// whole update of the supply mode, fuse check, decimation, offset correction,
// peak and packing is a single pass of logic from the input ports into the
// state and result registers, and the result register lets a new item enter
// while the previous result is still being taken. A stalled result holds the
// input back only when the result register is full and not being drained.
// Configuration registers are to be written through the csr_ port only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module current_fuse_and_sample_packer_unit
   import cfsp_pkg::*;
#(
   parameter int unsigned MAX_CAPTURE_BYTES = 800
)
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [9:0]  csr_wdata,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic [9:0]  req_sample,
   input  wire logic        req_high_shunt,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_byte_first,
   output logic [7:0]       rsp_byte_second,
   output logic [1:0]       rsp_bytes_out,
   output logic [1:0]       rsp_supply_state,
   output logic             rsp_tripped_now,
   output logic             rsp_capture_done,
   output logic             rsp_rejected,
   output logic [9:0]       rsp_peak_value,
   output logic             rsp_peak_below_limit
);

   // Cap on the byte count, one bit wider so that 1024 fits.
   localparam logic [CODE_W:0] MAX_LIMIT = (CODE_W+1)'(MAX_CAPTURE_BYTES);

   // Configuration registers.
   logic [CODE_W-1:0] trip_limit_ff;
   logic [CODE_W-1:0] zero_current_ff;
   logic [7:0]        decimation_ff;
   logic [CODE_W-1:0] capture_bytes_ff;

   // Block state.
   mode_type          mode_ff,          mode_in;
   logic              shunt_high_ff,    shunt_high_in;
   logic [CODE_W-1:0] offset_ff,        offset_in;
   logic [7:0]        dec_count_ff,     dec_count_in;
   phase_type         phase_ff,         phase_in;
   logic [BYTE_W-1:0] partial_ff,       partial_in;
   logic [CODE_W-1:0] emitted_ff,       emitted_in;
   logic [CODE_W-1:0] peak_ff,          peak_in;

   // Result register.
   logic              rsp_valid_ff;
   logic [7:0]        byte_first_ff,    byte_first_in;
   logic [7:0]        byte_second_ff,   byte_second_in;
   logic [1:0]        bytes_out_ff,     bytes_out_in;
   logic              tripped_ff,       tripped_in;
   logic              done_ff,          done_in;
   logic              rejected_ff,      rejected_in;
   logic [1:0]        state_ff;
   logic [CODE_W-1:0] peak_out_ff;
   logic              peak_low_ff;

   // Per-item decode.
   kind_type          kind;
   logic              accept;
   logic [CODE_W-1:0] inverted;
   logic              live;
   logic              sample_item;
   logic              trip;
   logic              trip_hit;
   logic [7:0]        dec_next;
   logic              kept;
   logic [CODE_W-1:0] corrected;
   logic [CODE_W-1:0] limit;
   logic [DIV10_PROD_W-1:0] div_prod;
   logic [CODE_W-1:0] offset_low;
   pack_result_type   pack;

   // Handshake: the result register frees up when it is empty or drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign kind      = kind_type'(req_kind);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         trip_limit_ff    <= TRIP_LIMIT_RESET;
         zero_current_ff  <= ZERO_CURRENT_RESET;
         decimation_ff    <= DECIMATION_RESET;
         capture_bytes_ff <= CAPTURE_BYTES_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_TRIP_LIMIT:    trip_limit_ff    <= csr_wdata;
            CSR_ZERO_CURRENT:  zero_current_ff  <= csr_wdata;
            CSR_DECIMATION:    decimation_ff    <= csr_wdata[7:0];
            CSR_CAPTURE_BYTES: capture_bytes_ff <= csr_wdata;
            default:           ;
         endcase
      end
   end

   // Byte limit of a capture and the low-shunt offset.
   always_comb begin
      limit = ({1'b0, capture_bytes_ff} > MAX_LIMIT) ? MAX_LIMIT[CODE_W-1:0]
                                                    : capture_bytes_ff;
      div_prod   = DIV10_PROD_W'(zero_current_ff) * DIV10_MUL;
      offset_low = CODE_W'(div_prod[DIV10_PROD_W-1:DIV10_SHIFT]);
   end

   // Fuse check, decimation and offset correction of a sample.
   always_comb begin
      inverted    = CODE_FULL_SCALE - req_sample;
      live        = (mode_ff == MODE_ON) || (mode_ff == MODE_CAPTURE);
      sample_item = (kind == KIND_SAMPLE) && live;
      trip        = shunt_high_ff ? (inverted == CODE_FULL_SCALE)
                                  : (inverted >= trip_limit_ff);
      trip_hit    = sample_item && trip;
      dec_next    = dec_count_ff + 8'd1;
      kept        = sample_item && !trip && (mode_ff == MODE_CAPTURE)
                    && (dec_next == decimation_ff);
      corrected   = (inverted > offset_ff) ? inverted - offset_ff : '0;
   end

   cfsp_pack u_pack (
      .value   (corrected),
      .phase   (phase_ff),
      .partial (partial_ff),
      .emitted (emitted_ff),
      .limit   (limit),
      .result  (pack)
   );

   // Next supply mode.
   always_comb begin
      mode_in = mode_ff;
      unique case (kind)
         KIND_POWER_ON:  mode_in = MODE_ON;
         KIND_START:     if (mode_ff == MODE_ON) mode_in = MODE_CAPTURE;
         KIND_POWER_OFF: mode_in = MODE_OFF;
         default: begin
            if (trip_hit) begin
               mode_in = MODE_TRIPPED;
            end else if (kept && pack.done) begin
               mode_in = MODE_ON;
            end
         end
      endcase
   end

   // Next datapath state.
   always_comb begin
      shunt_high_in = shunt_high_ff;
      offset_in     = offset_ff;
      dec_count_in  = dec_count_ff;
      phase_in      = phase_ff;
      partial_in    = partial_ff;
      emitted_in    = emitted_ff;
      peak_in       = peak_ff;
      unique case (kind)
         KIND_POWER_ON: begin
            shunt_high_in = req_high_shunt;
            offset_in     = req_high_shunt ? zero_current_ff : offset_low;
         end
         KIND_START: begin
            if (mode_ff == MODE_ON) begin
               peak_in    = '0;
               phase_in   = PHASE_0;
               partial_in = '0;
               emitted_in = '0;
            end
         end
         KIND_POWER_OFF: ;
         default: begin
            if (sample_item && !trip && (mode_ff == MODE_CAPTURE)) begin
               dec_count_in = dec_next;
            end
            if (kept) begin
               dec_count_in = '0;
               phase_in     = pack.phase_next;
               partial_in   = pack.partial_next;
               emitted_in   = pack.emitted_next;
               if (corrected > peak_ff) peak_in = corrected;
            end
         end
      endcase
   end

   // Result fields of this item.
   always_comb begin
      byte_first_in  = kept ? pack.byte_first  : '0;
      byte_second_in = kept ? pack.byte_second : '0;
      bytes_out_in   = kept ? pack.bytes_out   : '0;
      tripped_in     = trip_hit;
      done_in        = kept && pack.done;
      rejected_in    = (kind == KIND_START) && (mode_ff != MODE_ON);
   end

   // State registers, updated on each accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_OFF;
         shunt_high_ff <= 1'b0;
         offset_ff     <= '0;
         dec_count_ff  <= '0;
         phase_ff      <= PHASE_0;
         partial_ff    <= '0;
         emitted_ff    <= '0;
         peak_ff       <= '0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         shunt_high_ff <= shunt_high_in;
         offset_ff     <= offset_in;
         dec_count_ff  <= dec_count_in;
         phase_ff      <= phase_in;
         partial_ff    <= partial_in;
         emitted_ff    <= emitted_in;
         peak_ff       <= peak_in;
      end
   end

   // Result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_first_ff  <= byte_first_in;
         byte_second_ff <= byte_second_in;
         bytes_out_ff   <= bytes_out_in;
         tripped_ff     <= tripped_in;
         done_ff        <= done_in;
         rejected_ff    <= rejected_in;
         state_ff       <= mode_in;
         peak_out_ff    <= peak_in;
         peak_low_ff    <= peak_in < PEAK_LOW_LIMIT;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_byte_first       = byte_first_ff;
   assign rsp_byte_second      = byte_second_ff;
   assign rsp_bytes_out        = bytes_out_ff;
   assign rsp_supply_state     = state_ff;
   assign rsp_tripped_now      = tripped_ff;
   assign rsp_capture_done     = done_ff;
   assign rsp_rejected         = rejected_ff;
   assign rsp_peak_value       = peak_out_ff;
   assign rsp_peak_below_limit = peak_low_ff;

   // A trip always leaves the supply in the tripped mode.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tripped_now |-> rsp_supply_state == MODE_TRIPPED)
      else $error("trip reported without tripped mode");

   // A finished capture returns the supply to on.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_capture_done |-> rsp_supply_state == MODE_ON)
      else $error("capture end reported outside on mode");

   // Byte fields beyond the reported count are zero, and never three bytes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bytes_out != 2'd3
                    && (rsp_bytes_out == 2'd2 || rsp_byte_second == 8'd0)
                    && (rsp_bytes_out != 2'd0 || rsp_byte_first == 8'd0))
      else $error("byte fields inconsistent with byte count");

   // Bytes are only produced while a capture is running or just ending.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bytes_out != 2'd0 |->
         rsp_supply_state == MODE_CAPTURE || rsp_capture_done)
      else $error("bytes emitted outside a capture");

   // An accepted item always leaves a result waiting in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

endmodule
`default_nettype wire
